// ===== rtl/rich_pkg.sv =====
// Shared constants, codes and interface structs of the RLE color histogram.
package rich_pkg;

  // table size and derived widths
  localparam int unsigned MAX_COLORS = 1024;
  localparam int unsigned ADDR_W     = $clog2(MAX_COLORS);
  localparam int unsigned TOT_W      = $clog2(MAX_COLORS + 1);

  // fixed field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned DIST_W = 11;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned RGB_W  = 24;
  localparam int unsigned DIM_W  = 16;
  localparam int unsigned PIX_W  = 33;
  localparam int unsigned LEFT_W = 8;
  localparam int unsigned ENT_W  = RGB_W + CNT_W;

  // packet header: bit 7 marks a run, low bits hold length - 1
  localparam int unsigned RUN_BIT = 7;

  // operations carried in tuser
  localparam logic OP_STREAM = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_AW     = 1;
  localparam logic [CFG_AW-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_AW-1:0] REG_HEIGHT = 1'b1;

  // finished pixel offered by the parser
  typedef struct packed {
    logic              valid;
    logic [RGB_W-1:0]  rgb;
    logic [LEFT_W-1:0] n;
  } pix_t;

  // request to the color table
  typedef struct packed {
    logic              valid;
    logic              read;
    logic [IDX_W-1:0]  idx;
    logic [RGB_W-1:0]  rgb;
    logic [LEFT_W-1:0] n;
  } tbl_req_t;

  // completion from the color table
  typedef struct packed {
    logic             done;
    logic             valid;
    logic [RGB_W-1:0] rgb;
    logic [CNT_W-1:0] count;
  } tbl_rsp_t;

endpackage

// ===== rtl/rich_parser.sv =====
// Targa RLE packet parser: header decode, BGR assembly, pixel count and done flag.
module rich_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rich_pkg::CFG_AW-1:0]   cfg_addr_i,
  input  logic [rich_pkg::DIM_W-1:0]    cfg_wdata_i,
  input  logic                          take_i,
  input  logic [rich_pkg::BYTE_W-1:0]   byte_i,
  output rich_pkg::pix_t                pix_o,
  output logic                          done_o
);
  import rich_pkg::*;

  localparam logic [1:0] BIP_BLUE  = 2'd0;
  localparam logic [1:0] BIP_GREEN = 2'd1;
  localparam logic [1:0] BIP_RED   = 2'd2;

  logic [DIM_W-1:0]   width_q, height_q;
  logic [2*DIM_W-1:0] area_q;
  logic               phase_q, phase_d;
  logic               run_q, run_d;
  logic [LEFT_W-1:0]  left_q, left_d;
  logic [1:0]         bip_q, bip_d;
  logic [BYTE_W-1:0]  blue_q, blue_d;
  logic [BYTE_W-1:0]  green_q, green_d;
  logic [PIX_W-1:0]   counted_q, counted_d;
  logic [LEFT_W-1:0]  left_dec;

  assign done_o    = !phase_q && (counted_q >= PIX_W'(area_q));
  assign pix_o.valid = phase_q && (bip_q == BIP_RED);
  assign pix_o.rgb   = {byte_i, green_q, blue_q};
  assign pix_o.n     = run_q ? left_q : LEFT_W'(1);
  assign left_dec    = left_q - LEFT_W'(1);

  always_comb begin
    phase_d   = phase_q;
    run_d     = run_q;
    left_d    = left_q;
    bip_d     = bip_q;
    blue_d    = blue_q;
    green_d   = green_q;
    counted_d = counted_q;
    if (take_i) begin
      if (!phase_q) begin
        if (!done_o) begin
          run_d   = byte_i[RUN_BIT];
          left_d  = {1'b0, byte_i[RUN_BIT-1:0]} + LEFT_W'(1);
          bip_d   = BIP_BLUE;
          phase_d = 1'b1;
        end
      end else begin
        case (bip_q)
          BIP_BLUE: begin
            blue_d = byte_i;
            bip_d  = BIP_GREEN;
          end
          BIP_GREEN: begin
            green_d = byte_i;
            bip_d   = BIP_RED;
          end
          default: begin
            bip_d = BIP_BLUE;
            if (run_q) begin
              counted_d = counted_q + PIX_W'(left_q);
              left_d    = '0;
              phase_d   = 1'b0;
            end else begin
              counted_d = counted_q + PIX_W'(1);
              left_d    = left_dec;
              if (left_dec == '0) phase_d = 1'b0;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= '0;
      height_q  <= '0;
      area_q    <= '0;
      phase_q   <= 1'b0;
      run_q     <= 1'b0;
      left_q    <= '0;
      bip_q     <= BIP_BLUE;
      blue_q    <= '0;
      green_q   <= '0;
      counted_q <= '0;
    end else begin
      if (cfg_we_i && (cfg_addr_i == REG_WIDTH))  width_q  <= cfg_wdata_i;
      if (cfg_we_i && (cfg_addr_i == REG_HEIGHT)) height_q <= cfg_wdata_i;
      area_q    <= width_q * height_q;
      phase_q   <= phase_d;
      run_q     <= run_d;
      left_q    <= left_d;
      bip_q     <= bip_d;
      blue_q    <= blue_d;
      green_q   <= green_d;
      counted_q <= counted_d;
    end
  end

endmodule

// ===== rtl/rich_table.sv =====
// Color table: one RAM of {color, count}, linear search, read-modify-write update.
module rich_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rich_pkg::tbl_req_t          req_i,
  output rich_pkg::tbl_rsp_t          rsp_o,
  output logic [rich_pkg::TOT_W-1:0]  total_o,
  output logic                        overflow_o
);
  import rich_pkg::*;

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_READ = 2'd1;
  localparam logic [1:0] T_SCAN = 2'd2;

  logic [ENT_W-1:0]  mem_q [MAX_COLORS];
  logic [ENT_W-1:0]  rd_q;

  logic [1:0]        st_q, st_d;
  logic [TOT_W-1:0]  addr_q, addr_d;
  logic [TOT_W-1:0]  total_q, total_d;
  logic              ovf_q, ovf_d;
  logic              vld_q, vld_d;
  logic [RGB_W-1:0]  key_q, key_d;
  logic [LEFT_W-1:0] n_q, n_d;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_wa, mem_ra;
  logic [ENT_W-1:0]  mem_wd;

  logic [TOT_W-1:0]  prev_w;
  logic [CNT_W:0]    sum_w;
  logic [CNT_W-1:0]  sat_w;
  logic              hit_w;

  assign prev_w = addr_q - TOT_W'(1);
  assign sum_w  = {1'b0, rd_q[CNT_W-1:0]} + {{(CNT_W + 1 - LEFT_W){1'b0}}, n_q};
  assign sat_w  = sum_w[CNT_W] ? {CNT_W{1'b1}} : sum_w[CNT_W-1:0];
  assign hit_w  = (addr_q != '0) && (rd_q[CNT_W +: RGB_W] == key_q);

  assign total_o    = total_q;
  assign overflow_o = ovf_q;

  always_comb begin
    st_d    = st_q;
    addr_d  = addr_q;
    total_d = total_q;
    ovf_d   = ovf_q;
    vld_d   = vld_q;
    key_d   = key_q;
    n_d     = n_q;
    mem_we  = 1'b0;
    mem_wa  = prev_w[ADDR_W-1:0];
    mem_wd  = {key_q, sat_w};
    mem_re  = 1'b0;
    mem_ra  = addr_q[ADDR_W-1:0];
    rsp_o   = '0;
    case (st_q)
      T_IDLE: begin
        if (req_i.valid) begin
          if (req_i.read) begin
            mem_re = 1'b1;
            mem_ra = ADDR_W'(req_i.idx);
            vld_d  = {{TOT_W{1'b0}}, req_i.idx} < {{IDX_W{1'b0}}, total_q};
            st_d   = T_READ;
          end else begin
            key_d  = req_i.rgb;
            n_d    = req_i.n;
            addr_d = '0;
            st_d   = T_SCAN;
          end
        end
      end
      T_READ: begin
        rsp_o.done  = 1'b1;
        rsp_o.valid = vld_q;
        rsp_o.rgb   = vld_q ? rd_q[CNT_W +: RGB_W] : '0;
        rsp_o.count = vld_q ? rd_q[CNT_W-1:0] : '0;
        st_d        = T_IDLE;
      end
      T_SCAN: begin
        // rd_q holds the entry at addr_q - 1 once the first read is back
        if (hit_w) begin
          mem_we     = 1'b1;
          rsp_o.done = 1'b1;
          st_d       = T_IDLE;
        end else if (addr_q == total_q) begin
          rsp_o.done = 1'b1;
          st_d       = T_IDLE;
          if (total_q < TOT_W'(MAX_COLORS)) begin
            mem_we  = 1'b1;
            mem_wa  = total_q[ADDR_W-1:0];
            mem_wd  = {key_q, {(CNT_W - LEFT_W){1'b0}}, n_q};
            total_d = total_q + TOT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end else begin
          mem_re = 1'b1;
          addr_d = addr_q + TOT_W'(1);
        end
      end
      default: st_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    if (mem_re) rd_q <= mem_q[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= T_IDLE;
      addr_q  <= '0;
      total_q <= '0;
      ovf_q   <= 1'b0;
      vld_q   <= 1'b0;
    end else begin
      st_q    <= st_d;
      addr_q  <= addr_d;
      total_q <= total_d;
      ovf_q   <= ovf_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    n_q   <= n_d;
  end

endmodule

// ===== rtl/rle_image_color_histogram.sv =====
// Top level of the RLE targa color histogram: stream ports, sequencer, output register.
//
// Usage: after the fixed header of a 24-bit RLE targa image, feed the pixel-data bytes
// one word each on the s_axis channel with tuser = 0. Words with tuser = 1 read one table
// entry (entry_index). Each input word yields exactly one m_axis word carrying done,
// the number of distinct colors, the sticky overflow flag and, for reads, the entry.
// image_width / image_height are written on the cfg port (index 0 / 1) while idle.
//
// Timing: one word is in flight at a time; s_axis_tready_o is high only while the
// sequencer is idle. A header or first/second color byte passes EXEC and OUT into the
// output register; a read passes EXEC, WAIT (the table read) and OUT. The byte that
// completes a pixel runs a linear search of the color RAM in WAIT, one entry per
// cycle, before OUT; a hit ends the search early.
//
// The output register parts the two sides: a new word is accepted while a result
// still waits; when m_axis_tready_i stays low the finished result of the next word
// waits in the sequencer and tready stays low. Reset clears the parser, the counters
// and the flags at once; the RAM is not cleared, only entries below the count are read.
module rle_image_color_histogram (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write port
  input  logic                        cfg_we_i,
  input  logic [rich_pkg::CFG_AW-1:0] cfg_addr_i,
  input  logic [rich_pkg::DIM_W-1:0]  cfg_wdata_i,
  // input stream
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [23:0]                 s_axis_tdata_i,  // data_byte[7:0], entry_index[17:8]
  input  logic                        s_axis_tuser_i,  // operation
  // result stream
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // done_res[0], distinct_colors[11:1], overflow[12], entry_valid[13],
  // red[21:14], green[29:22], blue[37:30], count[69:38]
  output logic [71:0]                 m_axis_tdata_o
);
  import rich_pkg::*;

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]        st_q, st_d;
  logic              op_q;
  logic [BYTE_W-1:0] byte_q;
  logic [IDX_W-1:0]  idx_q;

  // entry fields of the pending result
  logic              ev_q, ev_d;
  logic [RGB_W-1:0]  col_q, col_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  logic              m_valid_q, m_valid_d;
  logic [71:0]       m_data_q, m_data_d;

  logic              accept_w;
  logic              take_w;
  logic              load_w;
  logic              done_w;
  logic              ovf_w;
  logic [TOT_W-1:0]  tot_w;
  pix_t              pix_w;
  tbl_req_t          req_w;
  tbl_rsp_t          rsp_w;

  assign s_axis_tready_o = (st_q == ST_IDLE);
  assign accept_w        = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  rich_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .take_i     (take_w),
    .byte_i     (byte_q),
    .pix_o      (pix_w),
    .done_o     (done_w)
  );

  rich_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_w),
    .rsp_o     (rsp_w),
    .total_o   (tot_w),
    .overflow_o(ovf_w)
  );

  // sequencer: decode the held word, hand pixels and reads to the table
  always_comb begin
    st_d   = st_q;
    ev_d   = ev_q;
    col_d  = col_q;
    cnt_d  = cnt_q;
    take_w = 1'b0;
    load_w = 1'b0;
    req_w       = '0;
    req_w.idx   = idx_q;
    req_w.rgb   = pix_w.rgb;
    req_w.n     = pix_w.n;
    case (st_q)
      ST_IDLE: begin
        if (accept_w) st_d = ST_EXEC;
      end
      ST_EXEC: begin
        ev_d  = 1'b0;
        col_d = '0;
        cnt_d = '0;
        if (op_q == OP_READ) begin
          req_w.valid = 1'b1;
          req_w.read  = 1'b1;
          st_d        = ST_WAIT;
        end else begin
          take_w = 1'b1;
          if (pix_w.valid) begin
            // last byte of a pixel: tally it before reporting
            req_w.valid = 1'b1;
            st_d        = ST_WAIT;
          end else begin
            st_d = ST_OUT;
          end
        end
      end
      ST_WAIT: begin
        if (rsp_w.done) begin
          ev_d  = rsp_w.valid;
          col_d = rsp_w.rgb;
          cnt_d = rsp_w.count;
          st_d  = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready_i) begin
          load_w = 1'b1;
          st_d   = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // output register; status fields show the state after the word was applied
  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (m_axis_tready_i) m_valid_d = 1'b0;
    if (load_w) begin
      m_valid_d = 1'b1;
      m_data_d  = {2'b00, cnt_q, col_q[7:0], col_q[15:8], col_q[23:16],
                   ev_q, ovf_w, DIST_W'(tot_w), done_w};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_w) begin
      op_q   <= s_axis_tuser_i;
      byte_q <= s_axis_tdata_i[BYTE_W-1:0];
      idx_q  <= s_axis_tdata_i[BYTE_W +: IDX_W];
    end
    ev_q     <= ev_d;
    col_q    <= col_d;
    cnt_q    <= cnt_d;
    m_data_q <= m_data_d;
  end

`ifndef NO_ASSERTIONS
  // one word at a time: an accept closes the input until the result is queued
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_w |=> !s_axis_tready_o)
    else $error("input accepted while a word is in flight");

  // the color count never passes the table size
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tot_w <= TOT_W'(MAX_COLORS))
    else $error("distinct color count beyond table size");

  // overflow is sticky
  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_w |=> ovf_w)
    else $error("overflow flag cleared");

  // overflow only with a full table
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_w |-> (tot_w == TOT_W'(MAX_COLORS)))
    else $error("overflow set while table not full");
`endif

endmodule
